FILE: design/rsp_pkg.sv
// ----------------------------------------------------------------------------
// rsp_pkg
// Shared types and constants for the rudder servo pulse generator.
// ----------------------------------------------------------------------------
package rsp_pkg;

    // Item operation codes.
    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_SET      = 2'd1,
        OP_RAW      = 2'd2,
        OP_REASSERT = 2'd3
    } op_t;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEUTRAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE = 3'd4;

    // Register reset values.
    localparam logic [15:0] PERIOD_RESET  = 16'd20000;
    localparam logic [11:0] NEUTRAL_RESET = 12'd1516;
    localparam logic [11:0] MIN_RESET     = 12'd1195;
    localparam logic [11:0] MAX_RESET     = 12'd1805;
    localparam logic        REVERSE_RESET = 1'b1;

    // Pulse width after reset, the home position.
    localparam logic [11:0] HOME_PULSE = 12'd1805;

    // Steering limits in Q2.14.
    localparam logic signed [15:0] STEER_ONE     = 16'sd16384;
    localparam logic signed [15:0] STEER_NEG_ONE = -16'sd16384;

    // Raw pulse limits in microseconds.
    localparam logic [15:0] RAW_LOW  = 16'd400;
    localparam logic [15:0] RAW_HIGH = 16'd2600;

    // Mapping accumulator width and the rounding constant for the 14-bit shift.
    localparam int ACC_W = 30;
    localparam logic signed [ACC_W-1:0] ROUND_HALF = 30'sd8192;

    // Mapping settings handed to the pulse mapper.
    typedef struct packed {
        logic [11:0] neutral;
        logic [11:0] min_p;
        logic [11:0] max_p;
        logic        reverse;
    } map_cfg_t;

    // Status of the tick being processed.
    typedef struct packed {
        logic level;
        logic start;
    } tick_stat_t;

endpackage

FILE: design/rudder_servo_pwm_output.sv
// A request passes from the input register through the mapping logic into the
// result register.
// Throughput: one request per cycle; a stalled result holds the input register.
// Reset: registers return to their defaults, steering homes to minus one,
// both compare registers to 1805 us and the period counter to zero.
// ----------------------------------------------------------------------------
// rudder_servo_pwm_output
// Single-channel servo pulse generator with steering, raw, reassert and tick requests.
// ----------------------------------------------------------------------------
module rudder_servo_pwm_output import rsp_pkg::*; #(
    parameter int COUNT_BITS = 16,
    parameter int PULSE_BITS = 12
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           op,
    input  logic signed [15:0]   steer_value,
    input  logic [15:0]          raw_pulse,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 pwm_out,
    output logic                 period_start,
    output logic [11:0]          pending_pulse,
    output logic signed [15:0]   steer_now,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);

    // Configuration registers.
    logic [15:0] period_reg;
    map_cfg_t    map_cfg_reg;

    // Input register.
    logic               s1_valid_reg;
    op_t                s1_op_reg;
    logic signed [15:0] s1_steer_reg;
    logic [15:0]        s1_raw_reg;

    // Block state.
    logic signed [15:0]    steer_reg;
    logic signed [15:0]    steer_next;
    logic [PULSE_BITS-1:0] shadow_reg;
    logic [PULSE_BITS-1:0] shadow_next;

    // Result register.
    logic               out_valid_reg;
    logic               pwm_reg;
    logic               start_reg;
    logic [11:0]        pending_reg;
    logic signed [15:0] steer_out_reg;

    logic                  advance;
    logic                  fire;
    logic signed [15:0]    steer_clamp;
    logic signed [15:0]    map_in;
    logic [PULSE_BITS-1:0] map_pulse;
    logic [15:0]           raw_clamp;
    logic                  is_tick;
    tick_stat_t            tick_stat;

    // The pipeline moves whenever the result register is free or being taken.
    assign advance   = !out_valid_reg || !out_stall;
    assign fire      = s1_valid_reg && advance;
    assign in_stall  = s1_valid_reg && !advance;
    assign cfg_ready = 1'b1;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg          <= PERIOD_RESET;
            map_cfg_reg.neutral <= NEUTRAL_RESET;
            map_cfg_reg.min_p   <= MIN_RESET;
            map_cfg_reg.max_p   <= MAX_RESET;
            map_cfg_reg.reverse <= REVERSE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PERIOD:  period_reg          <= cfg_data;
                REG_NEUTRAL: map_cfg_reg.neutral <= cfg_data[11:0];
                REG_MIN:     map_cfg_reg.min_p   <= cfg_data[11:0];
                REG_MAX:     map_cfg_reg.max_p   <= cfg_data[11:0];
                REG_REVERSE: map_cfg_reg.reverse <= cfg_data[0];
                default:     ;
            endcase
        end
    end

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_op_reg    <= op_t'(op);
            s1_steer_reg <= steer_value;
            s1_raw_reg   <= raw_pulse;
        end
    end

    // Clamp the requested steering to plus or minus one.
    always_comb
    begin
        if (s1_steer_reg < STEER_NEG_ONE)
        begin
            steer_clamp = STEER_NEG_ONE;
        end
        else if (s1_steer_reg > STEER_ONE)
        begin
            steer_clamp = STEER_ONE;
        end
        else
        begin
            steer_clamp = s1_steer_reg;
        end
    end

    // Clamp the raw pulse to the fixed raw range of 400 to 2600 us.
    always_comb
    begin
        if (s1_raw_reg < RAW_LOW)
        begin
            raw_clamp = RAW_LOW;
        end
        else if (s1_raw_reg > RAW_HIGH)
        begin
            raw_clamp = RAW_HIGH;
        end
        else
        begin
            raw_clamp = s1_raw_reg;
        end
    end

    // A set request maps its new value; a reassert maps the stored one.
    assign map_in = (s1_op_reg == OP_SET) ? steer_clamp : steer_reg;

    rsp_pulse_map #(
        .PULSE_BITS(PULSE_BITS)
    ) u_map (
        .steer(map_in),
        .cfg  (map_cfg_reg),
        .pulse(map_pulse)
    );

    // Next stored steering and shadow compare.
    always_comb
    begin
        steer_next  = steer_reg;
        shadow_next = shadow_reg;
        case (s1_op_reg)
            OP_TICK:
            begin
                shadow_next = shadow_reg;
            end
            OP_SET:
            begin
                steer_next  = steer_clamp;
                shadow_next = map_pulse;
            end
            OP_RAW:
            begin
                shadow_next = PULSE_BITS'(raw_clamp);
            end
            OP_REASSERT:
            begin
                shadow_next = map_pulse;
            end
            default:
            begin
                shadow_next = shadow_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steer_reg  <= STEER_NEG_ONE;
            shadow_reg <= PULSE_BITS'(HOME_PULSE);
        end
        else if (fire)
        begin
            steer_reg  <= steer_next;
            shadow_reg <= shadow_next;
        end
    end

    // Period counter runs on tick requests only.
    assign is_tick = (s1_op_reg == OP_TICK);

    rsp_period_timer #(
        .COUNT_BITS(COUNT_BITS),
        .PULSE_BITS(PULSE_BITS)
    ) u_timer (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick_en(fire && is_tick),
        .period (period_reg),
        .shadow (shadow_reg),
        .stat   (tick_stat)
    );

    // Result register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            pwm_reg       <= is_tick && tick_stat.level;
            start_reg     <= is_tick && tick_stat.start;
            pending_reg   <= shadow_next[11:0];
            steer_out_reg <= steer_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pwm_out       = pwm_reg;
    assign period_start  = start_reg;
    assign pending_pulse = pending_reg;
    assign steer_now     = steer_out_reg;

endmodule

FILE: design/rsp_pulse_map.sv
// ----------------------------------------------------------------------------
// rsp_pulse_map
// Maps a clamped steering value to a pulse width in microseconds.
// ----------------------------------------------------------------------------
module rsp_pulse_map import rsp_pkg::*; #(
    parameter int PULSE_BITS = 12
) (
    input  logic signed [15:0]           steer,
    input  map_cfg_t                     cfg,
    output logic        [PULSE_BITS-1:0] pulse
);

    localparam logic [15:0] PULSE_MAX = 16'((32'd1 << PULSE_BITS) - 32'd1);

    logic signed [15:0]      v;
    logic signed [12:0]      d;
    logic signed [28:0]      prod;
    logic signed [ACC_W-1:0] acc;
    logic        [15:0]      p;

    // Apply the direction setting; the input is clamped, so negation cannot overflow.
    assign v = cfg.reverse ? -steer : steer;

    // Pick the slope for the half of the range that the value lies in.
    always_comb
    begin
        if (!v[15])
        begin
            d = $signed({1'b0, cfg.max_p}) - $signed({1'b0, cfg.neutral});
        end
        else
        begin
            d = $signed({1'b0, cfg.neutral}) - $signed({1'b0, cfg.min_p});
        end
    end

    // Neutral plus value times slope, with half an LSB added for rounding.
    assign prod = v * d;
    assign acc  = $signed({4'b0, cfg.neutral, 14'b0}) + ACC_W'(prod) + ROUND_HALF;
    assign p    = acc[29:14];

    // Saturate the result to the pulse range.
    always_comb
    begin
        if (acc[ACC_W-1])
        begin
            pulse = '0;
        end
        else if (p > PULSE_MAX)
        begin
            pulse = PULSE_MAX[PULSE_BITS-1:0];
        end
        else
        begin
            pulse = p[PULSE_BITS-1:0];
        end
    end

endmodule

FILE: design/rsp_period_timer.sv
// ----------------------------------------------------------------------------
// rsp_period_timer
// Period counter and active compare register of the servo pulse.
// ----------------------------------------------------------------------------
module rsp_period_timer import rsp_pkg::*; #(
    parameter int COUNT_BITS = 16,
    parameter int PULSE_BITS = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  tick_en,
    input  logic [15:0]           period,
    input  logic [PULSE_BITS-1:0] shadow,
    output tick_stat_t            stat
);

    localparam int CMP_A = (COUNT_BITS > PULSE_BITS) ? COUNT_BITS : PULSE_BITS;
    localparam int CMP_W = (CMP_A > 16) ? CMP_A : 16;

    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic [PULSE_BITS-1:0] active_reg;
    logic [PULSE_BITS-1:0] active_eff;
    logic [COUNT_BITS-1:0] count_inc;
    logic                  at_zero;

    // The shadow compare takes over at the start of each period.
    assign at_zero    = (count_reg == '0);
    assign active_eff = at_zero ? shadow : active_reg;

    assign stat.start = at_zero;
    assign stat.level = CMP_W'(count_reg) < CMP_W'(active_eff);

    // Advance the counter and wrap at the period end or at the counter limit.
    assign count_inc = count_reg + COUNT_BITS'(1);

    always_comb
    begin
        if ((period == 16'd0) || (CMP_W'(count_inc) >= CMP_W'(period)))
        begin
            count_next = '0;
        end
        else
        begin
            count_next = count_inc;
        end
    end

    // Counter and active compare state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            active_reg <= PULSE_BITS'(HOME_PULSE);
        end
        else if (tick_en)
        begin
            count_reg  <= count_next;
            active_reg <= active_eff;
        end
    end

endmodule

FILE: design/rsp_checker.sv
// ----------------------------------------------------------------------------
// rsp_checker
// Port-level checks of the servo pulse generator, bound to the top level.
// ----------------------------------------------------------------------------
module rsp_checker import rsp_pkg::*; (
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic               pwm_out,
    input logic               period_start,
    input logic [11:0]        pending_pulse,
    input logic signed [15:0] steer_now
);

    // A stalled result stays valid and unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid &&
            $stable({pwm_out, period_start, pending_pulse, steer_now}))
        else $error("stalled result changed");

    // The input side only stalls behind a result that is waiting.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with free result register");

    // Reported steering lies within plus or minus one whenever a result is valid.
    a_steer_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (steer_now >= STEER_NEG_ONE) && (steer_now <= STEER_ONE))
        else $error("steering out of range");

endmodule

bind rudder_servo_pwm_output rsp_checker u_rsp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pwm_out      (pwm_out),
    .period_start (period_start),
    .pending_pulse(pending_pulse),
    .steer_now    (steer_now)
);
